// ----- hw/rtl/page_aligned_range_coalescer_unit_macros.svh -----
// assertion macros used by the checker file
`ifndef PAGE_ALIGNED_RANGE_COALESCER_UNIT_MACROS_SVH
`define PAGE_ALIGNED_RANGE_COALESCER_UNIT_MACROS_SVH

// same-cycle implication
`define PACRU_AST_IMM(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pacru check failed");

// next-cycle implication
`define PACRU_AST_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pacru check failed");

`endif

// ----- hw/rtl/pacru_pkg.sv -----
// types, widths and codes of the page aligned range coalescer
`default_nettype none
package pacru_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int ADDR_W      = 32;
   localparam int RLEN_W      = 32;
   localparam int LEN_W       = 33;
   localparam int END_W       = 34;
   localparam int PAGE_W      = 17;
   localparam int SUM_W       = LEN_W + IDX_W;
   localparam int REQ_W       = 2;
   localparam int STAT_W      = 2;
   localparam int OUT_CNT_W   = 5;
   localparam int EIDX_W      = 4;
   localparam int STEP_W      = $clog2(END_W + 1);

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [END_W-1:0]  value;
      logic [PAGE_W-1:0] divisor;
   } rem_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PAGE_W-1:0] rem;
   } rem_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MERGE_UP,
      ST_MERGE_WR,
      ST_ABS_RD,
      ST_ABS_CHK,
      ST_ABS_WR,
      ST_CMP_RD,
      ST_CMP_WR,
      ST_INS_GO,
      ST_INS_UP,
      ST_INS_FIND,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INS_WR,
      ST_READ_RD,
      ST_READ_CHK,
      ST_ALIGN_GO,
      ST_ALIGN_WAIT,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/pacru_ifs.sv -----
// request and response channel interfaces
`default_nettype none
interface pacru_req_if;
   logic                           valid;
   logic                           ready;
   logic [pacru_pkg::REQ_W-1:0]    req_type;
   logic [pacru_pkg::ADDR_W-1:0]   range_addr;
   logic [pacru_pkg::RLEN_W-1:0]   range_len;
   logic [pacru_pkg::EIDX_W-1:0]   entry_index;

   modport source (output valid, req_type, range_addr, range_len, entry_index, input ready);
   modport sink   (input valid, req_type, range_addr, range_len, entry_index, output ready);
endinterface

interface pacru_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pacru_pkg::STAT_W-1:0]     status;
   logic [pacru_pkg::OUT_CNT_W-1:0]  region_count;
   logic [pacru_pkg::LEN_W-1:0]      total_size;
   logic [pacru_pkg::ADDR_W-1:0]     entry_start;
   logic [pacru_pkg::LEN_W-1:0]      entry_length;

   modport source (output valid, status, region_count, total_size, entry_start, entry_length,
                   input ready);
   modport sink   (input valid, status, region_count, total_size, entry_start, entry_length,
                   output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pacru_rem_unit.sv -----
// bit-serial remainder unit, one dividend bit per cycle
`default_nettype none
module pacru_rem_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  pacru_pkg::rem_cmd_type cmd,
   output pacru_pkg::rem_rsp_type rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [pacru_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [pacru_pkg::PAGE_W-1:0]   r_ff, r_in;
   logic [pacru_pkg::END_W-1:0]    v_ff, v_in;
   logic [pacru_pkg::PAGE_W:0]     shifted;
   logic [pacru_pkg::PAGE_W:0]     diff;
   logic [pacru_pkg::PAGE_W-1:0]   r_next;

   assign shifted = {r_ff, v_ff[pacru_pkg::END_W-1]};
   assign diff    = shifted - {1'b0, cmd.divisor};
   assign r_next  = (shifted >= {1'b0, cmd.divisor}) ? diff[pacru_pkg::PAGE_W-1:0]
                                                    : shifted[pacru_pkg::PAGE_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      v_in    = v_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = pacru_pkg::STEP_W'(pacru_pkg::END_W);
         r_in    = '0;
         v_in    = cmd.value;
      end else if (busy_ff) begin
         r_in   = r_next;
         v_in   = v_ff << 1;
         cnt_in = cnt_ff - pacru_pkg::STEP_W'(1);
         if (cnt_ff == pacru_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      v_ff   <= v_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = r_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/page_aligned_range_coalescer_unit.sv -----
// Sorted table of page aligned memory regions with add, clear and read requests.
// One request is worked on at a time and ready is low while it runs; a finished
// item waits in the response register while the next request is accepted. An add
// walks the table entry by entry, moves entries one at a time, and runs every page
// rounding through one shared bit-serial remainder unit: a merge takes two
// roundings plus one per absorbed region, an insert two. Page size 0 acts as 1.
`default_nettype none
module page_aligned_range_coalescer_unit (
   input  logic                          clock,
   input  logic                          reset,
   pacru_req_if.sink                     req_bus,
   pacru_rsp_if.source                   rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [pacru_pkg::PAGE_W-1:0]  csr_wr_data
);

   localparam int IW = pacru_pkg::IDX_W;
   localparam int CW = pacru_pkg::CNT_W;
   localparam int EW = pacru_pkg::END_W;
   localparam int LW = pacru_pkg::LEN_W;
   localparam int AW = pacru_pkg::ADDR_W;
   localparam int SW = pacru_pkg::SUM_W;

   pacru_pkg::state_type      state_ff, state_in, ret_ff, ret_in;
   pacru_pkg::status_type     stat_ff, stat_in;
   logic [CW-1:0]             held_ff, held_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             src_ff, src_in;
   logic [SW-1:0]             total_ff, total_in;
   logic [pacru_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [pacru_pkg::RLEN_W-1:0] rlen_ff, rlen_in;
   logic [pacru_pkg::EIDX_W-1:0] ridx_ff, ridx_in;
   logic [EW-1:0]             tail_ff, tail_in;
   logic [AW-1:0]             start_ff, start_in;
   logic [LW-1:0]             cur_len_ff, cur_len_in;
   logic                      aln_up_ff, aln_up_in;
   logic [EW-1:0]             aln_val_ff, aln_val_in;
   logic [LW-1:0]             aln_res_ff, aln_res_in;
   logic [AW-1:0]             es_ff, es_in;
   logic [LW-1:0]             el_ff, el_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   pacru_pkg::status_type     rsp_stat_ff, rsp_stat_in;
   logic [CW-1:0]             rsp_cnt_ff, rsp_cnt_in;
   logic [LW-1:0]             rsp_total_ff, rsp_total_in;
   logic [AW-1:0]             rsp_es_ff, rsp_es_in;
   logic [LW-1:0]             rsp_el_ff, rsp_el_in;

   pacru_pkg::entry_type      mem_ff [pacru_pkg::MAX_REGIONS];
   pacru_pkg::entry_type      rd_data_ff;
   logic                      mem_we;
   logic [IW-1:0]             mem_waddr, mem_raddr;
   pacru_pkg::entry_type      mem_wdata;

   pacru_pkg::rem_cmd_type    rem_cmd;
   pacru_pkg::rem_rsp_type    rem_rsp;

   logic [pacru_pkg::PAGE_W-1:0] page_eff;
   logic [EW-1:0]             rd_ct, rd_ch, hi, down_res;
   logic [EW:0]               up_sum, up_res;
   logic [LW-1:0]             up_sat;
   logic [CW-1:0]             src_m1;
   logic                      out_free;

   assign page_eff = (page_ff == '0) ? pacru_pkg::PAGE_W'(1) : page_ff;
   assign rd_ch    = EW'(rd_data_ff.start);
   assign rd_ct    = rd_ch + EW'(rd_data_ff.length);
   assign hi       = (tail_ff > rd_ct) ? tail_ff : rd_ct;
   assign down_res = aln_val_ff - EW'(rem_rsp.rem);
   assign up_sum   = (EW+1)'(aln_val_ff) + (EW+1)'(page_eff) - (EW+1)'(rem_rsp.rem);
   assign up_res   = (rem_rsp.rem == '0) ? (EW+1)'(aln_val_ff) : up_sum;
   assign up_sat   = (up_res > (EW+1)'(pacru_pkg::LEN_MAX)) ? pacru_pkg::LEN_MAX
                                                            : up_res[LW-1:0];
   assign src_m1   = src_ff - CW'(1);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign rem_cmd.start   = (state_ff == pacru_pkg::ST_ALIGN_GO);
   assign rem_cmd.value   = aln_val_ff;
   assign rem_cmd.divisor = page_eff;

   pacru_rem_unit u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (rem_cmd),
      .rsp   (rem_rsp)
   );

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      stat_in    = stat_ff;
      held_in    = held_ff;
      idx_in     = idx_ff;
      src_in     = src_ff;
      total_in   = total_ff;
      page_in    = csr_wr_en ? csr_wr_data : page_ff;
      head_in    = head_ff;
      rlen_in    = rlen_ff;
      ridx_in    = ridx_ff;
      tail_in    = tail_ff;
      start_in   = start_ff;
      cur_len_in = cur_len_ff;
      aln_up_in  = aln_up_ff;
      aln_val_in = aln_val_ff;
      aln_res_in = aln_res_ff;
      es_in      = es_ff;
      el_in      = el_ff;
      mem_we     = 1'b0;
      mem_waddr  = idx_ff[IW-1:0];
      mem_wdata  = '{start: start_ff, length: aln_res_ff};
      mem_raddr  = idx_ff[IW-1:0];

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_total_in = rsp_total_ff;
      rsp_es_in    = rsp_es_ff;
      rsp_el_in    = rsp_el_ff;

      unique case (state_ff)
         pacru_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               head_in = req_bus.range_addr;
               rlen_in = req_bus.range_len;
               ridx_in = req_bus.entry_index;
               tail_in = EW'(req_bus.range_addr) + EW'(req_bus.range_len);
               stat_in = pacru_pkg::STAT_OK;
               es_in   = '0;
               el_in   = '0;
               idx_in  = '0;
               unique case (pacru_pkg::req_code_type'(req_bus.req_type))
                  pacru_pkg::REQ_ADD: begin
                     state_in = (held_ff == '0) ? pacru_pkg::ST_INS_GO : pacru_pkg::ST_SCAN_RD;
                  end
                  pacru_pkg::REQ_CLEAR: begin
                     held_in  = '0;
                     total_in = '0;
                     state_in = pacru_pkg::ST_RESP;
                  end
                  pacru_pkg::REQ_READ: begin
                     state_in = pacru_pkg::ST_READ_RD;
                  end
                  default: begin
                     state_in = pacru_pkg::ST_RESP;
                  end
               endcase
            end
         end
         pacru_pkg::ST_SCAN_RD: begin
            state_in = pacru_pkg::ST_SCAN_CHK;
         end
         pacru_pkg::ST_SCAN_CHK: begin
            if (EW'(head_ff) > rd_ct) begin
               idx_in   = idx_ff + CW'(1);
               state_in = (idx_ff + CW'(1) >= held_ff) ? pacru_pkg::ST_INS_GO
                                                       : pacru_pkg::ST_SCAN_RD;
            end else if (tail_ff < rd_ch) begin
               state_in = pacru_pkg::ST_INS_GO;
            end else begin
               tail_in    = hi;
               cur_len_in = rd_data_ff.length;
               aln_val_in = (EW'(head_ff) < rd_ch) ? EW'(head_ff) : rd_ch;
               aln_up_in  = 1'b0;
               ret_in     = pacru_pkg::ST_MERGE_UP;
               state_in   = pacru_pkg::ST_ALIGN_GO;
            end
         end
         pacru_pkg::ST_MERGE_UP: begin
            start_in   = aln_res_ff[AW-1:0];
            aln_val_in = tail_ff - EW'(aln_res_ff[AW-1:0]);
            aln_up_in  = 1'b1;
            ret_in     = pacru_pkg::ST_MERGE_WR;
            state_in   = pacru_pkg::ST_ALIGN_GO;
         end
         pacru_pkg::ST_MERGE_WR, pacru_pkg::ST_ABS_WR: begin
            mem_we     = 1'b1;
            total_in   = total_ff - SW'(cur_len_ff) + SW'(aln_res_ff);
            cur_len_in = aln_res_ff;
            tail_in    = EW'(start_ff) + EW'(aln_res_ff);
            src_in     = (state_ff == pacru_pkg::ST_MERGE_WR) ? idx_ff + CW'(1)
                                                              : src_ff + CW'(1);
            state_in   = pacru_pkg::ST_ABS_RD;
         end
         pacru_pkg::ST_ABS_RD: begin
            mem_raddr = src_ff[IW-1:0];
            if (src_ff >= held_ff) begin
               idx_in   = idx_ff + CW'(1);
               state_in = pacru_pkg::ST_CMP_RD;
            end else begin
               state_in = pacru_pkg::ST_ABS_CHK;
            end
         end
         pacru_pkg::ST_ABS_CHK: begin
            if (tail_ff < rd_ch) begin
               idx_in   = idx_ff + CW'(1);
               state_in = pacru_pkg::ST_CMP_RD;
            end else begin
               total_in   = total_ff - SW'(rd_data_ff.length);
               aln_val_in = hi - EW'(start_ff);
               aln_up_in  = 1'b1;
               ret_in     = pacru_pkg::ST_ABS_WR;
               state_in   = pacru_pkg::ST_ALIGN_GO;
            end
         end
         pacru_pkg::ST_CMP_RD: begin
            mem_raddr = src_ff[IW-1:0];
            if (src_ff >= held_ff) begin
               held_in  = idx_ff;
               state_in = pacru_pkg::ST_RESP;
            end else begin
               state_in = pacru_pkg::ST_CMP_WR;
            end
         end
         pacru_pkg::ST_CMP_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            idx_in    = idx_ff + CW'(1);
            src_in    = src_ff + CW'(1);
            state_in  = pacru_pkg::ST_CMP_RD;
         end
         pacru_pkg::ST_INS_GO: begin
            if (held_ff >= CW'(pacru_pkg::MAX_REGIONS)) begin
               stat_in  = pacru_pkg::STAT_FULL;
               state_in = pacru_pkg::ST_RESP;
            end else begin
               aln_val_in = EW'(head_ff);
               aln_up_in  = 1'b0;
               ret_in     = pacru_pkg::ST_INS_UP;
               state_in   = pacru_pkg::ST_ALIGN_GO;
            end
         end
         pacru_pkg::ST_INS_UP: begin
            start_in   = aln_res_ff[AW-1:0];
            aln_val_in = EW'(rlen_ff);
            aln_up_in  = 1'b1;
            ret_in     = pacru_pkg::ST_INS_FIND;
            state_in   = pacru_pkg::ST_ALIGN_GO;
         end
         pacru_pkg::ST_INS_FIND: begin
            cur_len_in = aln_res_ff;
            idx_in     = '0;
            state_in   = pacru_pkg::ST_FIND_RD;
         end
         pacru_pkg::ST_FIND_RD: begin
            if (idx_ff >= held_ff) begin
               src_in   = held_ff;
               state_in = pacru_pkg::ST_SHIFT_RD;
            end else begin
               state_in = pacru_pkg::ST_FIND_CHK;
            end
         end
         pacru_pkg::ST_FIND_CHK: begin
            if (start_ff > rd_data_ff.start) begin
               idx_in   = idx_ff + CW'(1);
               state_in = pacru_pkg::ST_FIND_RD;
            end else begin
               src_in   = held_ff;
               state_in = pacru_pkg::ST_SHIFT_RD;
            end
         end
         pacru_pkg::ST_SHIFT_RD: begin
            mem_raddr = src_m1[IW-1:0];
            state_in  = (src_ff <= idx_ff) ? pacru_pkg::ST_INS_WR : pacru_pkg::ST_SHIFT_WR;
         end
         pacru_pkg::ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = src_ff[IW-1:0];
            mem_wdata = rd_data_ff;
            src_in    = src_m1;
            state_in  = pacru_pkg::ST_SHIFT_RD;
         end
         pacru_pkg::ST_INS_WR: begin
            mem_we    = 1'b1;
            mem_wdata = '{start: start_ff, length: cur_len_ff};
            held_in   = held_ff + CW'(1);
            total_in  = total_ff + SW'(cur_len_ff);
            state_in  = pacru_pkg::ST_RESP;
         end
         pacru_pkg::ST_READ_RD: begin
            mem_raddr = ridx_ff[IW-1:0];
            if (CW'(ridx_ff) >= held_ff) begin
               stat_in  = pacru_pkg::STAT_RANGE;
               state_in = pacru_pkg::ST_RESP;
            end else begin
               state_in = pacru_pkg::ST_READ_CHK;
            end
         end
         pacru_pkg::ST_READ_CHK: begin
            es_in    = rd_data_ff.start;
            el_in    = rd_data_ff.length;
            state_in = pacru_pkg::ST_RESP;
         end
         pacru_pkg::ST_ALIGN_GO: begin
            state_in = pacru_pkg::ST_ALIGN_WAIT;
         end
         pacru_pkg::ST_ALIGN_WAIT: begin
            if (rem_rsp.done) begin
               aln_res_in = aln_up_ff ? up_sat : LW'(down_res);
               state_in   = ret_ff;
            end
         end
         pacru_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_cnt_in   = held_ff;
               rsp_total_in = (total_ff > SW'(pacru_pkg::LEN_MAX)) ? pacru_pkg::LEN_MAX
                                                                  : total_ff[LW-1:0];
               rsp_es_in    = es_ff;
               rsp_el_in    = el_ff;
               state_in     = pacru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pacru_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pacru_pkg::ST_IDLE;
         held_ff      <= '0;
         total_ff     <= '0;
         page_ff      <= pacru_pkg::PAGE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         total_ff     <= total_in;
         page_ff      <= page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff       <= ret_in;
      stat_ff      <= stat_in;
      idx_ff       <= idx_in;
      src_ff       <= src_in;
      head_ff      <= head_in;
      rlen_ff      <= rlen_in;
      ridx_ff      <= ridx_in;
      tail_ff      <= tail_in;
      start_ff     <= start_in;
      cur_len_ff   <= cur_len_in;
      aln_up_ff    <= aln_up_in;
      aln_val_ff   <= aln_val_in;
      aln_res_ff   <= aln_res_in;
      es_ff        <= es_in;
      el_ff        <= el_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_total_ff <= rsp_total_in;
      rsp_es_ff    <= rsp_es_in;
      rsp_el_ff    <= rsp_el_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[mem_raddr];
   end

   assign req_bus.ready        = (state_ff == pacru_pkg::ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_stat_ff;
   assign rsp_bus.region_count = pacru_pkg::OUT_CNT_W'(rsp_cnt_ff);
   assign rsp_bus.total_size   = rsp_total_ff;
   assign rsp_bus.entry_start  = rsp_es_ff;
   assign rsp_bus.entry_length = rsp_el_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/pacru_checker.sv -----
// port level checks of the range coalescer and their bind
`default_nettype none
`include "page_aligned_range_coalescer_unit_macros.svh"
module pacru_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [pacru_pkg::STAT_W-1:0]     status,
   input logic [pacru_pkg::OUT_CNT_W-1:0]  region_count,
   input logic [pacru_pkg::ADDR_W-1:0]     entry_start,
   input logic [pacru_pkg::LEN_W-1:0]      entry_length
);

   // a dropped add only happens on a full table
   `PACRU_AST_IMM(a_full_at_max, clock, reset, rsp_valid && status == pacru_pkg::STAT_FULL, region_count == pacru_pkg::OUT_CNT_W'(pacru_pkg::MAX_REGIONS))

   // a read past the count returns an empty entry
   `PACRU_AST_IMM(a_range_empty, clock, reset, rsp_valid && status == pacru_pkg::STAT_RANGE, entry_start == '0 && entry_length == '0)

   // one item at a time
   `PACRU_AST_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // stalled item holds
   `PACRU_AST_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(region_count))

endmodule

bind page_aligned_range_coalescer_unit pacru_checker u_pacru_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .status       (rsp_bus.status),
   .region_count (rsp_bus.region_count),
   .entry_start  (rsp_bus.entry_start),
   .entry_length (rsp_bus.entry_length)
);
`default_nettype wire
